FILE: design/rbft_pkg.sv
// Package for the rocket burn fuel tracker: request status codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package rbft_pkg;
    localparam int MASS_BITS_DEF = 24;
    localparam int EXP_FRAC_BITS_DEF = 24;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int SERIES_TERMS = 10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_POS = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    localparam logic [2:0] REG_DRY  = 3'd0;
    localparam logic [2:0] REG_LOAD = 3'd1;
    localparam logic [2:0] REG_REF  = 3'd2;
    localparam logic [2:0] REG_CRIT = 3'd3;
    localparam logic [2:0] REG_MAXV = 3'd4;
    localparam logic [2:0] REG_VE   = 3'd5;
endpackage

FILE: design/rbft_divider.sv
// Restoring bit-serial divider shared by the two divisions by register values in the tracker.
// Depends on nothing but its ports; one quotient bit per cycle.
`timescale 1ns / 1ps
module rbft_divider #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, quo_reg, den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial;

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: design/rocket_burn_fuel_tracker.sv
// Rocket burn fuel tracker: Tsiolkovsky fuel cost, burn checks and fuel bookkeeping.
// Uses rbft_pkg and one shared rbft_divider.
// A rejected burn or non-positive estimate runs only the fraction division after the input
// transfer; a costed request runs the velocity division, six reduction steps, ten series
// terms of a multiply and a divide step each, the cost and deduction steps and the fraction
// division, and skips the series terms when the exponential underflows.
// One request at a time: a new request is taken only once the previous result has been
// accepted. Reset is synchronous and active low, loads the register defaults and sets the
// fuel to its default load.
`timescale 1ns / 1ps
module rocket_burn_fuel_tracker
    import rbft_pkg::*;
#(
    parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // delta_v[20:0], zero fill
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], fuel_used[26:2], clamped[27], fuel_left[51:28],
    // total_mass[76:52], fuel_fraction[92:77], critical[93], empty_res[94], zero fill
    output logic [95:0] m_tdata
);
    localparam int F = EXP_FRAC_BITS;
    localparam int DW = 64;
    localparam int AW = F + 1;
    localparam int PW = 2 * F + 1;
    localparam int RW = F + 5;
    localparam int RS = F + 4;
    localparam int QW = 2 * F + 6;
    localparam int CPW = F + 26;
    localparam logic [63:0] ONE = 64'd1 << F;
    localparam logic [63:0] LN2F = (F < 32) ?
        ((64'(LN2_Q32) + (64'd1 << ((31 - F) % 32))) >> ((32 - F) % 64)) : 64'(LN2_Q32);
    localparam logic [63:0] MMASK = (64'd1 << MASS_BITS_DEF) - 64'd1;
    // Rounded-up reciprocals of the series term numbers, scaled by 2^RS.
    localparam logic [RW-1:0] RC1  = RW'(64'd1 << RS);
    localparam logic [RW-1:0] RC2  = RW'(((64'd1 << RS) + 64'd1) / 64'd2);
    localparam logic [RW-1:0] RC3  = RW'(((64'd1 << RS) + 64'd2) / 64'd3);
    localparam logic [RW-1:0] RC4  = RW'(((64'd1 << RS) + 64'd3) / 64'd4);
    localparam logic [RW-1:0] RC5  = RW'(((64'd1 << RS) + 64'd4) / 64'd5);
    localparam logic [RW-1:0] RC6  = RW'(((64'd1 << RS) + 64'd5) / 64'd6);
    localparam logic [RW-1:0] RC7  = RW'(((64'd1 << RS) + 64'd6) / 64'd7);
    localparam logic [RW-1:0] RC8  = RW'(((64'd1 << RS) + 64'd7) / 64'd8);
    localparam logic [RW-1:0] RC9  = RW'(((64'd1 << RS) + 64'd8) / 64'd9);
    localparam logic [RW-1:0] RC10 = RW'(((64'd1 << RS) + 64'd9) / 64'd10);

    typedef enum logic [3:0] {
        S_IDLE, S_X, S_K, S_SMUL, S_SDIV, S_EXP, S_CMUL, S_APPLY, S_FRAC, S_OUT
    } state_t;

    state_t        state_reg;
    logic [23:0]   dry_reg, fref_reg, maxv_reg, ve_reg, fuel_reg;
    logic [15:0]   crit_reg;
    logic          est_reg, clamp_reg;
    logic [20:0]   dv_reg;
    logic [1:0]    status_reg;
    logic [24:0]   used_reg;
    logic [63:0]   x_reg, p_reg;
    logic [5:0]    k_reg, k_new;
    logic [2:0]    kbit_reg;
    logic [PW-1:0] prod_reg, series_prod;
    logic [AW-1:0] acc_reg;
    logic [3:0]    term_reg;
    logic [15:0]   frac_reg;
    logic          go_reg;
    logic          div_start;
    logic [63:0]   div_a, div_b, div_q;
    logic          div_done;
    logic          positive;
    logic [24:0]   tot;
    logic [63:0]   k_step;
    logic          k_hit;
    logic [F-1:0]  r_op;
    logic [F:0]    p_op, series_n, series_q;
    logic [RW-1:0] recip;
    logic [QW-1:0] recip_prod;
    logic [CPW-1:0] cost_prod;

    rbft_divider #(.W(DW)) u_div (
        .aclk, .aresetn, .start(div_start), .dividend(div_a), .divisor(div_b),
        .done(div_done), .quotient(div_q)
    );

    assign positive = (s_tdata[20:0] != '0) && !s_tdata[20];
    assign tot = 25'(dry_reg) + 25'(fuel_reg);

    // Range reduction: one binary step of the quotient by ln 2 per cycle.
    assign k_step = LN2F << kbit_reg;
    assign k_hit  = (x_reg >= k_step);
    assign k_new  = k_hit ? (k_reg | (6'd1 << kbit_reg)) : k_reg;

    // Series term: product r*p, then division by term*ONE as a shift and a
    // reciprocal multiplication that is exact for quotients below 2^F.
    assign r_op        = x_reg[F-1:0];
    assign p_op        = p_reg[F:0];
    assign series_prod = r_op * p_op;
    assign series_n    = prod_reg[PW-1:F];
    assign recip_prod  = series_n * recip;
    assign series_q    = recip_prod[RS+F:RS];

    always_comb begin
        case (term_reg)
            4'd1:    recip = RC1;
            4'd2:    recip = RC2;
            4'd3:    recip = RC3;
            4'd4:    recip = RC4;
            4'd5:    recip = RC5;
            4'd6:    recip = RC6;
            4'd7:    recip = RC7;
            4'd8:    recip = RC8;
            4'd9:    recip = RC9;
            4'd10:   recip = RC10;
            default: recip = RC1;
        endcase
    end

    // Cost: total mass times one minus the exponential.
    assign cost_prod = tot * acc_reg;

    // Operand selection for the shared divider.
    always_comb begin
        div_a = '0;
        div_b = 64'd1;
        unique case (state_reg)
            S_X: begin
                div_a = 64'(dv_reg) << F;
                div_b = (ve_reg == '0) ? 64'd1 : 64'(ve_reg);
            end
            S_FRAC: begin
                div_a = 64'(fuel_reg) << 15;
                div_b = (fref_reg == '0) ? 64'd1 : 64'(fref_reg);
            end
            default: ;
        endcase
    end

    // Sequencer: the divider is started on entry to each dividing state.
    assign div_start = go_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            dry_reg   <= 24'(500000 & MMASK);
            fref_reg  <= 24'(50000 & MMASK);
            crit_reg  <= 16'd1638;
            maxv_reg  <= 24'd15000;
            ve_reg    <= 24'd2941995;
            fuel_reg  <= 24'(50000 & MMASK);
            m_tvalid  <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_DRY:  dry_reg <= 24'(64'(cfg_wdata) & MMASK);
                    REG_LOAD: fuel_reg <= 24'(64'(cfg_wdata) & MMASK);
                    REG_REF:  fref_reg <= 24'(64'(cfg_wdata) & MMASK);
                    REG_CRIT: crit_reg <= cfg_wdata[15:0];
                    REG_MAXV: maxv_reg <= {4'd0, cfg_wdata[19:0]};
                    REG_VE:   ve_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        est_reg    <= s_tuser;
                        dv_reg     <= s_tdata[20:0];
                        used_reg   <= '0;
                        clamp_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        go_reg     <= 1'b1;
                        if (s_tuser) begin
                            state_reg <= positive ? S_X : S_FRAC;
                        end else if (!positive) begin
                            status_reg <= ST_NOT_POS;
                            state_reg  <= S_FRAC;
                        end else if (24'(s_tdata[19:0]) > maxv_reg) begin
                            status_reg <= ST_LIMIT;
                            state_reg  <= S_FRAC;
                        end else if (fuel_reg == '0) begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_FRAC;
                        end else begin
                            state_reg <= S_X;
                        end
                    end
                end
                S_X: if (div_done) begin
                    x_reg <= div_q;
                    k_reg <= '0;
                    kbit_reg <= 3'd5;
                    state_reg <= S_K;
                end
                S_K: begin
                    // The remainder r is left in x_reg; k of 63 means exp underflows.
                    if (k_hit) begin
                        x_reg <= x_reg - k_step;
                    end
                    k_reg <= k_new;
                    if (kbit_reg == 3'd0) begin
                        p_reg <= ONE;
                        term_reg <= 4'(SERIES_TERMS);
                        state_reg <= (k_new == 6'd63) ? S_EXP : S_SMUL;
                    end else begin
                        kbit_reg <= kbit_reg - 1'b1;
                    end
                end
                S_SMUL: begin
                    prod_reg <= series_prod;
                    state_reg <= S_SDIV;
                end
                S_SDIV: begin
                    p_reg <= ONE - 64'(series_q);
                    if (term_reg == 4'd1) begin
                        state_reg <= S_EXP;
                    end else begin
                        term_reg <= term_reg - 1'b1;
                        state_reg <= S_SMUL;
                    end
                end
                S_EXP: begin
                    acc_reg <= AW'(ONE - ((k_reg == 6'd63) ? 64'd0 : (p_reg >> k_reg)));
                    state_reg <= S_CMUL;
                end
                S_CMUL: begin
                    used_reg <= cost_prod[F+24:F];
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (!est_reg) begin
                        if (used_reg > 25'(fuel_reg)) begin
                            used_reg <= 25'(fuel_reg);
                            clamp_reg <= 1'b1;
                            fuel_reg <= '0;
                        end else begin
                            fuel_reg <= fuel_reg - used_reg[23:0];
                        end
                    end
                    go_reg <= 1'b1;
                    state_reg <= S_FRAC;
                end
                S_FRAC: if (div_done) begin
                    frac_reg <= (div_q > 64'hFFFF) ? 16'hFFFF : div_q[15:0];
                    m_tvalid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    m_tvalid <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    assign m_tdata = {1'b0, (fuel_reg == '0), (frac_reg <= crit_reg), frac_reg, tot,
                      fuel_reg, clamp_reg, used_reg, status_reg};
endmodule

FILE: design/rbft_checker.sv
// Port-level checker for the rocket burn fuel tracker, bound to the top level.
// Depends on rbft_pkg for status codes.
`timescale 1ns / 1ps
module rbft_checker
    import rbft_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    // No request is taken while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    // After an input transfer the block is busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready held after transfer");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    // Empty flag agrees with the fuel left.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[94] == (m_tdata[51:28] == '0))) else $error("empty flag");
    // A rejected burn reports no fuel used.
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[26:2] == '0 && !m_tdata[27])
        else $error("rejected burn used fuel");
endmodule

bind rocket_burn_fuel_tracker rbft_checker u_rbft_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
